@@ rtl/assert_macros.svh @@
// Assertion macros shared by the demodulator RTL.
// Used only by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

@@ rtl/amdemod_pkg.sv @@
// Package for the AM envelope demodulator: constants, types, commands.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package amdemod_pkg;
  localparam int SIGNAL_FRAC_BITS_DEF = 14;
  localparam int COEF_FRAC_BITS_DEF   = 30;
  localparam int LP_GUARD             = 6;
  localparam int GAIN_FRAC            = 16;
  localparam int ADDR_W               = 5;

  localparam logic [ADDR_W-1:0] REG_B0     = 5'd0;
  localparam logic [ADDR_W-1:0] REG_B1     = 5'd4;
  localparam logic [ADDR_W-1:0] REG_B2     = 5'd8;
  localparam logic [ADDR_W-1:0] REG_A1     = 5'd12;
  localparam logic [ADDR_W-1:0] REG_A2     = 5'd16;
  localparam logic [ADDR_W-1:0] REG_TARGET = 5'd20;
  localparam logic [ADDR_W-1:0] REG_VOLUME = 5'd24;
  localparam logic [ADDR_W-1:0] REG_DECIM  = 5'd28;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FF, ST_FB, ST_LPO, ST_SQ, ST_SQRT, ST_HP, ST_AGC,
    ST_LVL, ST_DIV, ST_GAIN, ST_VOL, ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic ff;
    logic fb;
    logic lpo;
    logic sqrt_start;
    logic hp;
    logic agc;
    logic div_start;
    logic gain;
    logic vol;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic keep;
  } dp_stat_t;
endpackage
`default_nettype wire

@@ rtl/amdemod_ctrl.sv @@
// Sequencer for the demodulator datapath.
// Depends on amdemod_pkg.
`timescale 1ns / 1ps
`default_nettype none
module amdemod_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   out_busy,
  output amdemod_pkg::dp_cmd_t        cmd,
  input  wire amdemod_pkg::dp_stat_t  stat
);
  import amdemod_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_FF;
        end
      end
      ST_FF:  begin cmd.ff = 1'b1;  state_nxt = ST_FB; end
      ST_FB:  begin cmd.fb = 1'b1;  state_nxt = ST_LPO; end
      ST_LPO: begin cmd.lpo = 1'b1; state_nxt = ST_SQ; end
      ST_SQ: begin
        cmd.sqrt_start = 1'b1;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: if (stat.sqrt_done) state_nxt = ST_HP;
      ST_HP:  begin cmd.hp = 1'b1; state_nxt = ST_AGC; end
      ST_AGC: begin
        cmd.agc = 1'b1;
        state_nxt = ST_LVL;
      end
      ST_LVL: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: if (stat.div_done) state_nxt = ST_GAIN;
      ST_GAIN: begin
        cmd.gain = 1'b1;
        state_nxt = stat.keep ? ST_VOL : ST_IDLE;
      end
      ST_VOL: begin cmd.vol = 1'b1; state_nxt = ST_OUT; end
      ST_OUT: if (!out_busy) begin
        cmd.out_load = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/amdemod_dp.sv @@
// Datapath: biquads, envelope root, DC block, AGC divide, volume.
// Depends on amdemod_pkg.
`timescale 1ns / 1ps
`default_nettype none
module amdemod_dp #(
  parameter int SIGNAL_FRAC_BITS = amdemod_pkg::SIGNAL_FRAC_BITS_DEF,
  parameter int COEF_FRAC_BITS   = amdemod_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire amdemod_pkg::dp_cmd_t  cmd,
  output amdemod_pkg::dp_stat_t      stat,
  input  wire logic signed [15:0]    sample_i,
  input  wire logic signed [15:0]    sample_q,
  input  wire logic signed [31:0]    coef_b0,
  input  wire logic signed [31:0]    coef_b1,
  input  wire logic signed [31:0]    coef_b2,
  input  wire logic signed [31:0]    coef_a1,
  input  wire logic signed [31:0]    coef_a2,
  input  wire logic [14:0]           agc_target,
  input  wire logic [15:0]           volume,
  input  wire logic [7:0]            decim_n,
  output logic signed [15:0]         audio_sample
);
  import amdemod_pkg::*;
  localparam int C = COEF_FRAC_BITS;
  localparam int S = SIGNAL_FRAC_BITS;
  localparam int LPS = C - LP_GUARD;
  localparam longint DC_POLE = ((99 * (64'sd1 <<< C)) + 50) / 100;
  localparam longint ATTACK  = ((64'sd1 <<< C) + 50) / 100;
  localparam longint DECAY   = ((64'sd1 <<< C) + 5000) / 10000;
  localparam longint FL_RAW  = ((64'sd1 <<< S) + 5000) / 10000;
  localparam longint LFLOOR  = (FL_RAW > 0) ? FL_RAW : 64'sd1;
  localparam longint GMAX    = 64'sd100 <<< GAIN_FRAC;
  localparam longint GMIN    = ((64'sd1 <<< GAIN_FRAC) + 5) / 10;
  localparam int NUM_W = 15 + S + GAIN_FRAC;
  localparam int DQ_W  = NUM_W;

  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    if (v > 96'sd2147483647) return 32'sh7fffffff;
    if (v < -96'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [15:0] xi_r[2], xq_r[2], si_r, sq_r;
  logic signed [31:0] yi_r[2], yq_r[2];
  logic signed [95:0] ffi_r, ffq_r, fbi_r, fbq_r;
  logic signed [31:0] lpi_r, lpq_r;
  logic [63:0] rem_r, res_r, bit_r;
  logic        sq_busy_r;
  logic signed [31:0] env_r, dcx_r, dcy_r, hp_r;
  logic [31:0] lvl_r;
  logic [NUM_W-1:0] dnum_r, dquo_r;
  logic [32:0] drem_r;
  logic [6:0]  dcnt_r;
  logic        div_busy_r;
  logic signed [31:0] agc_r;
  logic [7:0]  dcount_r;
  logic signed [15:0] audio_r;

  // lowpass combinational terms
  logic signed [95:0] ffi_c, ffq_c, fbi_c, fbq_c, acci, accq;
  always_comb begin
    ffi_c = 96'(48'(coef_b0) * 48'(si_r)) + 96'(48'(coef_b1) * 48'(xi_r[0]))
            + 96'(48'(coef_b2) * 48'(xi_r[1]));
    ffq_c = 96'(48'(coef_b0) * 48'(sq_r)) + 96'(48'(coef_b1) * 48'(xq_r[0]))
            + 96'(48'(coef_b2) * 48'(xq_r[1]));
    fbi_c = (96'(64'(coef_a1) * 64'(yi_r[0])) >>> LP_GUARD)
            + (96'(64'(coef_a2) * 64'(yi_r[1])) >>> LP_GUARD);
    fbq_c = (96'(64'(coef_a1) * 64'(yq_r[0])) >>> LP_GUARD)
            + (96'(64'(coef_a2) * 64'(yq_r[1])) >>> LP_GUARD);
    acci = (ffi_r <<< (S - LP_GUARD)) - fbi_r + (96'sd1 <<< (LPS - 1));
    accq = (ffq_r <<< (S - LP_GUARD)) - fbq_r + (96'sd1 <<< (LPS - 1));
  end

  logic [31:0] ai, aq;
  assign ai = lpi_r[31] ? 32'(-lpi_r) : lpi_r;
  assign aq = lpq_r[31] ? 32'(-lpq_r) : lpq_r;

  // highpass and AGC terms
  logic signed [95:0] hacc;
  logic signed [31:0] hp_c;
  logic signed [63:0] mag, dlt;
  logic signed [95:0] step;
  logic signed [63:0] lvl_c;
  always_comb begin
    hacc = (96'(env_r - 96'(dcx_r)) <<< C) + 96'(DC_POLE) * 96'(dcy_r)
           + (96'sd1 <<< (C - 1));
    hp_c = sat32(hacc >>> C);
    mag  = hp_r[31] ? -64'(hp_r) : 64'(hp_r);
    dlt  = mag - 64'($unsigned(lvl_r));
    step = (96'(dlt) * ((mag > 64'($unsigned(lvl_r))) ? 96'(ATTACK) : 96'(DECAY))
           + (96'sd1 <<< (C - 1))) >>> C;
    lvl_c = 64'($unsigned(lvl_r)) + 64'(step);
    if (lvl_c < LFLOOR) lvl_c = LFLOOR;
  end

  logic [32:0] dtry;
  assign dtry = {drem_r[31:0], dnum_r[NUM_W-1]} - {1'b0, lvl_r};

  logic signed [63:0] gain_c;
  logic signed [95:0] agc_acc, vprod;
  logic signed [95:0] vq;
  always_comb begin
    gain_c = 64'(dquo_r);
    if (gain_c > GMAX) gain_c = GMAX;
    if (gain_c < GMIN) gain_c = GMIN;
    agc_acc = (96'(hp_r) * 96'(gain_c) + (96'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    vprod = 96'(agc_r) * 96'($signed({1'b0, volume}));
    vq = vprod[95] ? -((-vprod) >>> (S + 8)) : (vprod >>> (S + 8));
  end

  logic [63:0] rb;
  assign rb = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xi_r[0] <= '0; xi_r[1] <= '0; xq_r[0] <= '0; xq_r[1] <= '0;
      yi_r[0] <= '0; yi_r[1] <= '0; yq_r[0] <= '0; yq_r[1] <= '0;
      dcx_r <= '0; dcy_r <= '0;
      lvl_r <= 32'(LFLOOR);
      dcount_r <= '0;
      sq_busy_r <= 1'b0;
      div_busy_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        si_r <= sample_i;
        sq_r <= sample_q;
      end
      if (cmd.ff) begin
        ffi_r <= ffi_c;
        ffq_r <= ffq_c;
        fbi_r <= fbi_c;
        fbq_r <= fbq_c;
      end
      if (cmd.fb) begin
        lpi_r <= sat32(acci >>> LPS);
        lpq_r <= sat32(accq >>> LPS);
      end
      if (cmd.lpo) begin
        xi_r[1] <= xi_r[0]; xi_r[0] <= si_r;
        xq_r[1] <= xq_r[0]; xq_r[0] <= sq_r;
        yi_r[1] <= yi_r[0]; yi_r[0] <= lpi_r;
        yq_r[1] <= yq_r[0]; yq_r[0] <= lpq_r;
      end
      if (cmd.sqrt_start) begin
        rem_r <= 64'(ai) * 64'(ai) + 64'(aq) * 64'(aq);
        res_r <= '0;
        bit_r <= 64'd1 << 62;
        sq_busy_r <= 1'b1;
      end else if (sq_busy_r) begin
        if (rem_r >= rb) begin
          rem_r <= rem_r - rb;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) sq_busy_r <= 1'b0;
      end
      if (cmd.hp) begin
        env_r <= (res_r > 64'h7fffffff) ? 32'sh7fffffff : res_r[31:0];
      end
      if (cmd.agc) begin
        hp_r  <= hp_c;
        dcx_r <= env_r;
        dcy_r <= hp_c;
      end
      if (cmd.div_start) begin
        lvl_r <= lvl_c[31:0];
        dnum_r <= NUM_W'(agc_target) << (S + GAIN_FRAC);
        drem_r <= '0;
        dquo_r <= '0;
        dcnt_r <= 7'(NUM_W);
        div_busy_r <= 1'b1;
      end else if (div_busy_r) begin
        dnum_r <= dnum_r << 1;
        if (!dtry[32]) begin
          drem_r <= dtry;
          dquo_r <= {dquo_r[DQ_W-2:0], 1'b1};
        end else begin
          drem_r <= {drem_r[31:0], dnum_r[NUM_W-1]};
          dquo_r <= {dquo_r[DQ_W-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 7'd1;
        if (dcnt_r == 7'd1) div_busy_r <= 1'b0;
      end
      if (cmd.gain) begin
        agc_r <= sat32(agc_acc);
        if (9'(dcount_r) + 9'd1 < 9'(decim_n)) begin
          dcount_r <= dcount_r + 8'd1;
        end else begin
          dcount_r <= '0;
        end
      end
      if (cmd.vol) begin
        audio_r <= (vq > 96'sd32767) ? 16'sh7fff :
                   (vq < -96'sd32768) ? 16'sh8000 : vq[15:0];
      end
    end
  end

  logic keep_now;
  assign keep_now = !(9'(dcount_r) + 9'd1 < 9'(decim_n));
  assign stat.sqrt_done = sq_busy_r && bit_r[0];
  assign stat.div_done  = div_busy_r && (dcnt_r == 7'd1);
  assign stat.keep      = keep_now;
  assign audio_sample   = audio_r;
endmodule
`default_nettype wire

@@ rtl/am_envelope_demodulator_core.sv @@
// Top level of the AM envelope demodulator: register port, sequencer, datapath.
// Depends on amdemod_pkg, amdemod_ctrl, amdemod_dp and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// One I/Q request is taken at a time. Each passes through the accept state,
// the lowpass states FF, FB and LPO, a state to square, the two-bit-per-step
// square root, highpass and level states, the restoring divide for the AGC
// gain, a gain state, and for a kept sample a volume and an output state.
// The square root and divider set the rate. A kept sample waits in the output
// register while out_stall is high; a following kept sample waits for it to
// be delivered before the next request is taken.
module am_envelope_demodulator_core #(
  parameter int SIGNAL_FRAC_BITS = amdemod_pkg::SIGNAL_FRAC_BITS_DEF,
  parameter int COEF_FRAC_BITS   = amdemod_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [15:0]           in_sample_i,
  input  wire logic signed [15:0]           in_sample_q,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [15:0]                out_audio_sample,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [amdemod_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import amdemod_pkg::*;
  logic signed [31:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [14:0] tgt_r;
  logic [15:0] vol_r;
  logic [7:0]  dec_r;
  logic        out_valid_r;
  logic signed [15:0] dp_audio;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= 32'sd23687; b1_r <= 32'sd47374; b2_r <= 32'sd23687;
      a1_r <= -32'sd2133170670; a2_r <= 32'sd1059525482;
      tgt_r <= 15'd5000; vol_r <= 16'd12800; dec_r <= 8'd42;
    end else if (wr) begin
      unique case (paddr)
        REG_B0:     b0_r <= pwdata;
        REG_B1:     b1_r <= pwdata;
        REG_B2:     b2_r <= pwdata;
        REG_A1:     a1_r <= pwdata;
        REG_A2:     a2_r <= pwdata;
        REG_TARGET: tgt_r <= pwdata[14:0];
        REG_VOLUME: vol_r <= pwdata[15:0];
        REG_DECIM:  dec_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_B0:     prdata = b0_r;
      REG_B1:     prdata = b1_r;
      REG_B2:     prdata = b2_r;
      REG_A1:     prdata = a1_r;
      REG_A2:     prdata = a2_r;
      REG_TARGET: prdata = {17'd0, tgt_r};
      REG_VOLUME: prdata = {16'd0, vol_r};
      REG_DECIM:  prdata = {24'd0, dec_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_audio_sample <= dp_audio;
  end
  assign out_valid = out_valid_r;

  amdemod_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall,
    .out_busy(out_valid_r && out_stall), .cmd, .stat
  );

  amdemod_dp #(
    .SIGNAL_FRAC_BITS(SIGNAL_FRAC_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .sample_i(in_sample_i), .sample_q(in_sample_q),
    .coef_b0(b0_r), .coef_b1(b1_r), .coef_b2(b2_r),
    .coef_a1(a1_r), .coef_a2(a2_r),
    .agc_target(tgt_r), .volume(vol_r), .decim_n(dec_r),
    .audio_sample(dp_audio)
  );

  `CHK_IMPL(a_load_idle, cmd.load, !in_stall)
  `CHK_IMPL(a_out_no_clobber, cmd.out_load, !(out_valid_r && out_stall))
  `CHK_NEXT(a_out_set, cmd.out_load, out_valid)
endmodule
`default_nettype wire

@@ sim/tb_am_envelope_demodulator_core.sv @@
// Testbench for am_envelope_demodulator_core: directed and random I/Q requests,
// APB register settings between phases, and an in-order software predictor.
// Depends on amdemod_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_am_envelope_demodulator_core;
  import amdemod_pkg::*;

  localparam int SIG_FB = SIGNAL_FRAC_BITS_DEF;
  localparam int COEF_FB = COEF_FRAC_BITS_DEF;
  localparam longint DC_POLE = ((64'd99 << COEF_FB) + 64'd50) / 64'd100;
  localparam longint ATTACK = ((64'd1 << COEF_FB) + 64'd50) / 64'd100;
  localparam longint DECAY = ((64'd1 << COEF_FB) + 64'd5000) / 64'd10000;
  localparam longint FLOOR_RAW = ((64'd1 << SIG_FB) + 64'd5000) / 64'd10000;
  localparam longint LVL_FLOOR = (FLOOR_RAW > 0) ? FLOOR_RAW : 1;
  localparam longint GAIN_MAX = 64'd100 << GAIN_FRAC;
  localparam longint GAIN_MIN = ((64'd1 << GAIN_FRAC) + 64'd5) / 64'd10;
  localparam int STALL_LIMIT = 50000;

  typedef struct {
    logic signed [15:0] i;
    logic signed [15:0] q;
  } iq_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_sample_i = '0;
  logic signed [15:0] in_sample_q = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_audio_sample;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  am_envelope_demodulator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_i(in_sample_i), .in_sample_q(in_sample_q),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_audio_sample(out_audio_sample),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of registers and state
  longint b0, b1, b2, a1, a2, target, vol, decim;
  int xi_hist[2], xq_hist[2], yi_hist[2], yq_hist[2];
  int hp_prev_in, hp_prev_out;
  longint level;
  int decim_cnt;

  iq_req_t pending_iq[$];
  logic signed [15:0] audio_expected[$];
  int err_cnt = 0;
  int idle_mode = 0;
  int quiet_cycles = 0;

  initial forever #5 clk = ~clk;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic int lowpass(int x, ref int xh[2], ref int yh[2]);
    longint ff, fb, acc;
    int y;
    ff = b0 * longint'(x) + b1 * longint'(xh[0]) + b2 * longint'(xh[1]);
    fb = ((a1 * longint'(yh[0])) >>> LP_GUARD) + ((a2 * longint'(yh[1])) >>> LP_GUARD);
    acc = ff * (64'sd1 <<< (SIG_FB - LP_GUARD)) - fb;
    y = sat32(rnd_shift(acc, COEF_FB - LP_GUARD));
    xh[1] = xh[0];
    xh[0] = x;
    yh[1] = yh[0];
    yh[0] = y;
    return y;
  endfunction

  function automatic void demod_step(iq_req_t r);
    int yi, yq, env, hp, agc;
    longint unsigned ai, aq, root;
    longint hacc, mag, k, gain, prod, qv;
    yi = lowpass(int'(r.i), xi_hist, yi_hist);
    yq = lowpass(int'(r.q), xq_hist, yq_hist);
    ai = (yi < 0) ? -longint'(yi) : longint'(yi);
    aq = (yq < 0) ? -longint'(yq) : longint'(yq);
    root = int_sqrt(ai * ai + aq * aq);
    env = (root > 64'd2147483647) ? 32'sh7fffffff : int'(root);
    hacc = (longint'(env) - longint'(hp_prev_in)) * (64'sd1 <<< COEF_FB)
           + DC_POLE * longint'(hp_prev_out);
    hp = sat32(rnd_shift(hacc, COEF_FB));
    hp_prev_in = env;
    hp_prev_out = hp;
    mag = (hp < 0) ? -longint'(hp) : longint'(hp);
    k = (mag > level) ? ATTACK : DECAY;
    level = level + rnd_shift((mag - level) * k, COEF_FB);
    if (level < LVL_FLOOR) level = LVL_FLOOR;
    gain = (target <<< (SIG_FB + GAIN_FRAC)) / level;
    if (gain > GAIN_MAX) gain = GAIN_MAX;
    if (gain < GAIN_MIN) gain = GAIN_MIN;
    agc = sat32(rnd_shift(longint'(hp) * gain, GAIN_FRAC));
    decim_cnt++;
    if (decim_cnt < decim) return;
    decim_cnt = 0;
    prod = longint'(agc) * vol;
    qv = (prod >= 0) ? (prod >>> (SIG_FB + 8)) : -((-prod) >>> (SIG_FB + 8));
    if (qv > 32767) qv = 32767;
    if (qv < -32768) qv = -32768;
    audio_expected.push_back(qv[15:0]);
  endfunction

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      REG_B0: b0 = longint'(signed'(val));
      REG_B1: b1 = longint'(signed'(val));
      REG_B2: b2 = longint'(signed'(val));
      REG_A1: a1 = longint'(signed'(val));
      REG_A2: a2 = longint'(signed'(val));
      REG_TARGET: target = longint'(val[14:0]);
      REG_VOLUME: vol = longint'(val[15:0]);
      REG_DECIM: decim = longint'(val[7:0]);
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] cb0, logic [31:0] cb1, logic [31:0] cb2,
                           logic [31:0] ca1, logic [31:0] ca2, logic [31:0] tgt,
                           logic [31:0] v, logic [31:0] d);
    reg_write(REG_B0, cb0);
    reg_write(REG_B1, cb1);
    reg_write(REG_B2, cb2);
    reg_write(REG_A1, ca1);
    reg_write(REG_A2, ca2);
    reg_write(REG_TARGET, tgt);
    reg_write(REG_VOLUME, v);
    reg_write(REG_DECIM, d);
  endtask

  task automatic push_iq(int si, int sq);
    iq_req_t r;
    r.i = si[15:0];
    r.q = sq[15:0];
    pending_iq.push_back(r);
  endtask

  task automatic push_random(int n);
    int amp;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: amp = 32767;
        1: amp = 4000;
        2: amp = 300;
        default: amp = 20;
      endcase
      push_iq($urandom_range(2 * amp) - amp, $urandom_range(2 * amp) - amp);
    end
  endtask

  task automatic drain();
    while (pending_iq.size() != 0 || audio_expected.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic bit sender_idle();
    if (idle_mode == 1) return $urandom_range(99) < 88;
    if (idle_mode == 3) return $urandom_range(99) < 7;
    return 1'b0;
  endfunction

  function automatic bit receiver_stall();
    if (idle_mode == 2) return $urandom_range(99) < 88;
    if (idle_mode == 3) return $urandom_range(99) < 7;
    return 1'b0;
  endfunction

  // request driver
  always @(posedge clk) begin
    logic fire;
    fire = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        demod_step(pending_iq.pop_front());
      end
      if (!in_valid || fire) begin
        if (pending_iq.size() != 0 && !sender_idle()) begin
          in_valid <= 1'b1;
          in_sample_i <= pending_iq[0].i;
          in_sample_q <= pending_iq[0].q;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    logic signed [15:0] exp_audio;
    if (rst_n && out_valid && !out_stall) begin
      if (audio_expected.size() == 0) begin
        $error("unexpected result audio_sample=%0d", out_audio_sample);
        err_cnt++;
      end else begin
        exp_audio = audio_expected.pop_front();
        if (out_audio_sample !== exp_audio) begin
          $error("audio_sample expected %0d actual %0d", exp_audio, out_audio_sample);
          err_cnt++;
        end
      end
    end
    out_stall <= rst_n ? receiver_stall() : 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    b0 = 23687; b1 = 47374; b2 = 23687;
    a1 = -2133170670; a2 = 1059525482;
    target = 5000; vol = 12800; decim = 42;
    xi_hist = '{0, 0}; xq_hist = '{0, 0}; yi_hist = '{0, 0}; yq_hist = '{0, 0};
    hp_prev_in = 0; hp_prev_out = 0;
    level = LVL_FLOOR;
    decim_cnt = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes at reset coefficients, every sample kept
    reg_write(REG_DECIM, 32'd1);
    push_iq(0, 0);
    push_iq(32767, 32767);
    push_iq(-32768, -32768);
    push_iq(32767, -32768);
    push_iq(-32768, 32767);
    push_iq(-1, 1);
    for (int k = 0; k < 6; k++) push_iq(32767, 32767);
    for (int k = 0; k < 4; k++) push_iq(0, 0);
    for (int k = 0; k < 4; k++) push_iq((k % 2) ? -32768 : 32767, 0);
    push_iq(16'h5555, 16'haaaa);
    push_iq(-21846, 21845);
    drain();

    // zero target and zero factor; loudest volume
    idle_mode = 1;
    write_all(32'd23687, 32'd47374, 32'd23687, 32'h80da_4a12, 32'h3f26_3b6a,
              32'd0, 32'd65535, 32'd0);
    push_random(40);
    drain();

    // coefficient extremes drive the lowpass into saturation; zero volume, then loudest
    idle_mode = 2;
    write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
              32'h8000_0000, 32'd32767, 32'd0, 32'd3);
    push_random(30);
    drain();
    reg_write(REG_VOLUME, 32'd65535);
    push_random(30);
    drain();

    idle_mode = 3;
    write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 32'd1, 32'd256, 32'd2);
    push_random(40);
    drain();

    // largest factor, then lowered below the running count
    idle_mode = 0;
    reg_write(REG_DECIM, 32'd255);
    push_random(260);
    drain();
    reg_write(REG_DECIM, 32'd2);
    push_random(20);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      idle_mode = ph % 4;
      if ($urandom_range(1)) begin
        write_all(32'd23687, 32'd47374, 32'd23687, 32'h80da_4a12, 32'h3f26_3b6a,
                  $urandom_range(32767), $urandom, $urandom_range(6));
      end else begin
        write_all($urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom_range(1, 8));
      end
      push_random(30);
      drain();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
